>>> hdl/lpr_pkg.sv
// shared types and constants of the line pixel rasterizer
package lpr_pkg;

  // fixed field widths
  localparam int CoordFieldW = 12;
  localparam int ColorW      = 24;
  localparam int FrameW      = 11;
  localparam int AddrW       = 20;

  // stream word widths
  localparam int InDataW  = 4 * CoordFieldW + ColorW;
  localparam int OutDataW = 48;

  // parameter defaults
  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 1024;
  localparam int DefCoordBits = 12;

  // reset value of the frame size registers
  localparam logic [FrameW-1:0] FrameReset = FrameW'(1024);

  // input kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef logic [ColorW-1:0] color_t;

endpackage

>>> hdl/line_pixel_rasterizer_unit.sv
// first-octant bresenham line rasterizer with clipping and linear addressing
// a step word with a line armed shows its pixel word in the cycle after it is accepted
// throughput: one input word per cycle while the output register is empty or taken; it frees on the cycle it is taken
// start words and step words on an idle line give no output word
// reset (rst, synchronous) disarms the line, empties the output register and sets the
// frame size to 1024 by 1024; no clearing pass is needed
module line_pixel_rasterizer_unit #(
  parameter int MAX_WIDTH  = lpr_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = lpr_pkg::DefMaxHeight,
  parameter int COORD_BITS = lpr_pkg::DefCoordBits
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [lpr_pkg::FrameW-1:0]   cfg_data,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // x_start[11:0], y_start[23:12], x_end[35:24], y_end[47:36], line_color[71:48]
  input  logic [lpr_pkg::InDataW-1:0]  s_tdata,
  // kind[0]
  input  logic                         s_tuser,
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // pixel_address[19:0], pixel_color[43:20], zero[47:44]
  output logic [lpr_pkg::OutDataW-1:0] m_tdata,
  // write_enable[0]
  output logic                         m_tuser,
  // last_pixel
  output logic                         m_tlast
);
  import lpr_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int EXTW = (CB > CoordFieldW) ? CB : CoordFieldW;
  localparam int ROWW = CB + 2;
  localparam int EW   = 2 * CB + 8;
  localparam int CMPW = (ROWW > FrameW + 1) ? ROWW : FrameW + 1;
  localparam int PRDW = 2 * FrameW + 1;

  // frame size registers
  logic [FrameW-1:0] frame_width;
  logic [FrameW-1:0] frame_height;

  // line state
  logic                   line_active;
  logic signed [CB-1:0]   cur_col;
  logic signed [ROWW-1:0] cur_row;
  logic signed [CB-1:0]   stop_col;
  logic signed [EW-1:0]   error_term;
  logic signed [CB+1:0]   inc_straight;
  logic signed [CB+2:0]   inc_diagonal;
  color_t                 held_color;

  // output register
  logic [AddrW-1:0] out_addr;
  color_t           out_color;
  logic             out_we;
  logic             out_last;

  // input decode
  logic [EXTW-1:0]      xs_z, ys_z, xe_z, ye_z;
  logic signed [CB-1:0] xs, ys, xe, ye;
  logic signed [CB:0]   dx, dy;
  logic                 in_fire, is_start, is_step;

  // step datapath
  logic signed [CMPW-1:0] col_x, row_x, width_x, height_x;
  logic signed [CB:0]     col_inc;
  logic                   in_frame, last_now;
  logic [PRDW-1:0]        addr_full;

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign is_start = in_fire && (s_tuser == KIND_START);
  assign is_step  = in_fire && (s_tuser == KIND_STEP) && line_active;

  // coordinates as COORD_BITS two's complement
  assign xs_z = EXTW'(s_tdata[CoordFieldW-1:0]);
  assign ys_z = EXTW'(s_tdata[2*CoordFieldW-1:CoordFieldW]);
  assign xe_z = EXTW'(s_tdata[3*CoordFieldW-1:2*CoordFieldW]);
  assign ye_z = EXTW'(s_tdata[4*CoordFieldW-1:3*CoordFieldW]);
  assign xs = signed'(xs_z[CB-1:0]);
  assign ys = signed'(ys_z[CB-1:0]);
  assign xe = signed'(xe_z[CB-1:0]);
  assign ye = signed'(ye_z[CB-1:0]);
  assign dx = (CB+1)'(xe) - (CB+1)'(xs);
  assign dy = (CB+1)'(ye) - (CB+1)'(ys);

  // clip test and address of the current pixel
  assign col_x    = CMPW'(cur_col);
  assign row_x    = CMPW'(cur_row);
  assign width_x  = signed'(CMPW'(frame_width));
  assign height_x = signed'(CMPW'(frame_height));
  assign in_frame = (col_x >= 0) && (col_x < width_x) && (row_x >= 0) && (row_x < height_x);
  assign col_inc  = (CB+1)'(cur_col) + (CB+1)'(1);
  assign last_now = col_inc >= (CB+1)'(stop_col);
  assign addr_full = PRDW'(row_x[FrameW-1:0]) * PRDW'(frame_width)
                   + PRDW'(col_x[FrameW-1:0]);

  // frame size registers, saturated to the parameter limits
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FrameReset;
      frame_height <= FrameReset;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FRAME_WIDTH) begin
        frame_width <= (int'(cfg_data) > MAX_WIDTH) ? FrameW'(MAX_WIDTH) : cfg_data;
      end else begin
        frame_height <= (int'(cfg_data) > MAX_HEIGHT) ? FrameW'(MAX_HEIGHT) : cfg_data;
      end
    end
  end

  // line state: load on start, advance on step
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active  <= 1'b0;
      cur_col      <= '0;
      cur_row      <= '0;
      stop_col     <= '0;
      error_term   <= '0;
      inc_straight <= '0;
      inc_diagonal <= '0;
      held_color   <= '0;
    end else if (is_start) begin
      line_active  <= xs < xe;
      cur_col      <= xs;
      cur_row      <= ROWW'(ys);
      stop_col     <= xe;
      inc_straight <= (CB+2)'(dy) <<< 1;
      inc_diagonal <= ((CB+3)'(dy) <<< 1) - ((CB+3)'(dx) <<< 1);
      error_term   <= EW'(((CB+3)'(dy) <<< 1) - (CB+3)'(dx));
      held_color   <= s_tdata[InDataW-1:4*CoordFieldW];
    end else if (is_step) begin
      if (!error_term[EW-1]) begin
        cur_row    <= cur_row + ROWW'(1);
        error_term <= error_term + EW'(inc_diagonal);
      end else begin
        error_term <= error_term + EW'(inc_straight);
      end
      cur_col <= col_inc[CB-1:0];
      if (last_now) begin
        line_active <= 1'b0;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= is_step;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (is_step) begin
      out_addr  <= in_frame ? addr_full[AddrW-1:0] : '0;
      out_color <= held_color;
      out_we    <= in_frame;
      out_last  <= last_now;
    end
  end

  assign m_tdata = {(OutDataW-AddrW-ColorW)'(0), out_color, out_addr};
  assign m_tuser = out_we;
  assign m_tlast = out_last;

  // a step on an armed line always yields a word
  a_step_gives_word: assert property (@(posedge clk) disable iff (rst)
    is_step |=> m_tvalid)
    else $error("step on armed line gave no output word");

  // the last pixel disarms the line
  a_last_disarms: assert property (@(posedge clk) disable iff (rst)
    (is_step && last_now) |=> !line_active)
    else $error("line still armed after last pixel");

  // clipped pixels carry a zero address
  a_clip_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[AddrW-1:0] == '0))
    else $error("clipped pixel with nonzero address");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

>>> tb/testbench.sv
// self-checking stream testbench for the bresenham line pixel rasterizer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpr_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int HoldOffCycles = 300;

  // one input word as offered on the slave side
  typedef struct packed {
    logic              kind;
    logic [11:0]       x_start;
    logic [11:0]       y_start;
    logic [11:0]       x_end;
    logic [11:0]       y_end;
    logic [ColorW-1:0] color;
  } line_word_t;

  // one pixel write as seen on the master side
  typedef struct packed {
    logic [AddrW-1:0] addr;
    color_t           color;
    logic             write_en;
    logic             is_last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_FRAME_WIDTH;
  logic [FrameW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic s_tuser = KIND_STEP;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  line_pixel_rasterizer_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // rasterizer state mirrored by the testbench
  int     frame_w = DefMaxWidth;
  int     frame_h = DefMaxHeight;
  logic   armed = 1'b0;
  int     col = 0;
  int     row = 0;
  int     stop = 0;
  longint err = 0;
  int     step_straight = 0;
  int     step_diag = 0;
  color_t pen_color = '0;

  line_word_t pending_words[$];
  pixel_t     expected_pixels[$];
  line_word_t offered_word;

  int   send_gap = 0;
  int   recv_gap = 0;
  int   recv_hold = 0;
  logic stall_request = 1'b0;
  logic no_gaps = 1'b0;
  int   errors = 0;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // reset, once
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 72) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  // advance the line state by one accepted word
  task automatic raster_step(input line_word_t w);
    pixel_t px;
    logic   inside_frame;
    int     dx;
    int     dy;
    if (w.kind == KIND_START) begin
      col = int'($signed(w.x_start));
      row = int'($signed(w.y_start));
      stop = int'($signed(w.x_end));
      dx = stop - col;
      dy = int'($signed(w.y_end)) - row;
      step_straight = 2 * dy;
      step_diag = 2 * dy - 2 * dx;
      err = 2 * dy - dx;
      pen_color = w.color;
      armed = col < stop;
    end else if (armed) begin
      inside_frame = col >= 0 && col < frame_w && row >= 0 && row < frame_h;
      px.addr = inside_frame ? AddrW'(row * frame_w + col) : '0;
      px.color = pen_color;
      px.write_en = inside_frame;
      px.is_last = col + 1 >= stop;
      expected_pixels.push_back(px);
      if (err >= 0) begin
        row++;
        err += step_diag;
      end else begin
        err += step_straight;
      end
      col++;
      if (px.is_last) armed = 1'b0;
    end
  endtask

  // register write, only while the block is drained
  task automatic write_frame_reg(input logic idx, input int val);
    int v;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= FrameW'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    v = val & 'h7FF;
    if (idx == CFG_FRAME_WIDTH) frame_w = (v > DefMaxWidth) ? DefMaxWidth : v;
    else frame_h = (v > DefMaxHeight) ? DefMaxHeight : v;
  endtask

  function automatic line_word_t step_word();
    line_word_t w;
    w.kind = KIND_STEP;
    w.x_start = 12'($urandom);
    w.y_start = 12'($urandom);
    w.x_end = 12'($urandom);
    w.y_end = 12'($urandom);
    w.color = ColorW'($urandom);
    return w;
  endfunction

  function automatic line_word_t start_word(input int xs, input int ys, input int xe,
                                            input int ye, input color_t c);
    line_word_t w;
    w.kind = KIND_START;
    w.x_start = 12'(xs);
    w.y_start = 12'(ys);
    w.x_end = 12'(xe);
    w.y_end = 12'(ye);
    w.color = c;
    return w;
  endfunction

  task automatic queue_steps(input int n);
    repeat (n) pending_words.push_back(step_word());
  endtask

  // field extremes, empty and reversed lines, restart, frame corner, idle steps
  task automatic queue_directed();
    pending_words.push_back(start_word(0, 0, 5, 2, 24'hFFFFFF));
    queue_steps(6);
    pending_words.push_back(start_word(-2048, -2048, 2047, 2047, 24'h000000));
    queue_steps(3);
    pending_words.push_back(start_word(2046, 1023, 2047, -2048, 24'hA5A5A5));
    queue_steps(1);
    pending_words.push_back(start_word(5, 5, 5, 9, 24'h5A5A5A));
    queue_steps(1);
    pending_words.push_back(start_word(7, 0, -3, 0, 24'h0F0F0F));
    queue_steps(1);
    pending_words.push_back(start_word(1021, 1021, 1025, 1025, 24'h123456));
    queue_steps(4);
    pending_words.push_back(start_word(-2, 0, 1, -5, 24'hFEDCBA));
    queue_steps(3);
  endtask

  // mostly whole lines near the frame, some arbitrary starts and stray steps
  task automatic queue_random_words(input int count);
    line_word_t w;
    int added;
    int len;
    int steps;
    int xs;
    int ys;
    int roll;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        pending_words.push_back(step_word());
        added += 1;
      end else begin
        if (roll < 14) begin
          w = step_word();
          w.kind = KIND_START;
          steps = $urandom_range(0, 6);
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
          xs = int'($urandom_range(0, frame_w + 6)) - 3;
          ys = int'($urandom_range(0, frame_h + 6)) - 3;
          w = start_word(xs, ys, xs + len, ys + int'($urandom_range(0, 4 * len)) - len,
                         ColorW'($urandom));
          // some lines are cut short by the next start
          steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1)
                                              : len + $urandom_range(0, 2);
        end
        pending_words.push_back(w);
        queue_steps(steps);
        added += steps + 1;
      end
    end
  endtask

  // wait until every word is taken and every pixel has come back
  // sampled at the falling edge so the driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_pixels.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // input side driver
  always @(posedge clk) begin
    logic offer;
    offer = s_tvalid;
    if (rst) begin
      offer = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        raster_step(offered_word);
        offer = 1'b0;
        send_gap = pick_gap();
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() != 0) begin
          offered_word = pending_words.pop_front();
          s_tdata <= {offered_word.color, offered_word.y_end, offered_word.x_end,
                      offered_word.y_start, offered_word.x_start};
          s_tuser <= offered_word.kind;
          offer = 1'b1;
        end
      end
    end
    s_tvalid <= offer;
  end

  // output side monitor and ready generation
  always @(posedge clk) begin
    pixel_t want;
    logic [AddrW-1:0] got_addr;
    color_t got_color;
    logic [OutDataW-AddrW-ColorW-1:0] got_pad;
    got_addr = m_tdata[AddrW-1:0];
    got_color = m_tdata[AddrW+ColorW-1:AddrW];
    got_pad = m_tdata[OutDataW-1:AddrW+ColorW];
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected pixel word: addr %h color %h we %b last %b", $time,
                 got_addr, got_color, m_tuser, m_tlast);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (got_addr !== want.addr || got_color !== want.color || got_pad !== '0 ||
            m_tuser !== want.write_en || m_tlast !== want.is_last) begin
          $display("%0t pixel mismatch: expected addr %h color %h we %b last %b pad 0,",
                   $time, want.addr, want.color, want.write_en, want.is_last,
                   " got addr %h color %h we %b last %b pad %h",
                   got_addr, got_color, m_tuser, m_tlast, got_pad);
          errors++;
        end
      end
      recv_gap = pick_gap();
    end else if (m_tready && $urandom_range(0, 15) == 0) begin
      recv_gap = pick_gap();
    end
    // long hold-off so the block backs up into its input
    if (stall_request) begin
      stall_request = 1'b0;
      recv_hold = HoldOffCycles;
    end
    if (recv_hold > 0) begin
      recv_hold--;
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no progress
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // phases of stimulus under different frame sizes
  initial begin
    @(negedge rst);
    queue_directed();
    wait_drained();

    write_frame_reg(CFG_FRAME_WIDTH, 1);
    write_frame_reg(CFG_FRAME_HEIGHT, 1);
    queue_random_words(60);
    wait_drained();

    // width saturates, zero height clips everything
    write_frame_reg(CFG_FRAME_WIDTH, 2047);
    write_frame_reg(CFG_FRAME_HEIGHT, 0);
    queue_random_words(60);
    wait_drained();

    write_frame_reg(CFG_FRAME_WIDTH, 37);
    write_frame_reg(CFG_FRAME_HEIGHT, 19);
    queue_random_words(70);
    stall_request = 1'b1;
    wait_drained();

    // full frame, back to back on both sides
    no_gaps = 1'b1;
    write_frame_reg(CFG_FRAME_WIDTH, 1024);
    write_frame_reg(CFG_FRAME_HEIGHT, 1024);
    queue_random_words(70);
    wait_drained();
    no_gaps = 1'b0;

    write_frame_reg(CFG_FRAME_WIDTH, $urandom_range(1, 1024));
    write_frame_reg(CFG_FRAME_HEIGHT, $urandom_range(1, 1024));
    queue_random_words(70);
    wait_drained();

    write_frame_reg(CFG_FRAME_WIDTH, 1500);
    write_frame_reg(CFG_FRAME_HEIGHT, 3);
    queue_random_words(60);
    wait_drained();

    repeat (8) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
